// ===== sv/spft_pkg.sv =====
package spft_pkg;

  localparam int KEY_W  = 18;
  localparam int MASK_W = 32;

  typedef enum logic [1:0] {
    REQ_LOOKUP   = 2'd0,
    REQ_NEIGHBOR = 2'd1,
    REQ_DEST     = 2'd2,
    REQ_UNUSED   = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_OWN         = 3'd1,
    ST_UNREACHABLE = 3'd2,
    ST_BAD_NEIGH   = 3'd3,
    ST_NO_DEFAULT  = 3'd4,
    ST_FULL        = 3'd5
  } status_t;

  localparam logic [1:0] KIND_UNREACH = 2'd0;
  localparam logic [1:0] KIND_UP      = 2'd1;
  localparam logic [1:0] KIND_DOWN    = 2'd2;
  localparam logic [1:0] KIND_BOTH    = 2'd3;

  localparam logic [2:0] CFG_UP_COUNT   = 3'd0;
  localparam logic [2:0] CFG_DOWN_COUNT = 3'd1;
  localparam logic [2:0] CFG_OWN_TYPE   = 3'd2;
  localparam logic [2:0] CFG_OWN_A      = 3'd3;
  localparam logic [2:0] CFG_OWN_B      = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EXEC = 3'b100
  } state_t;

  // scan packet handed from cell to cell
  typedef struct packed {
    logic              found;
    logic              free_found;
    logic [1:0]        kind;
    logic [MASK_W-1:0] slots;
  } scan_t;

  // broadcast entry write
  typedef struct packed {
    logic              set;
    logic              clr;
    logic [KEY_W-1:0]  key;
    logic [1:0]        kind;
    logic [MASK_W-1:0] slots;
  } wr_t;

endpackage

// ===== sv/spft_cell.sv =====
module spft_cell #(
  parameter int IDX_W = 6,
  parameter int INDEX = 0
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [spft_pkg::KEY_W-1:0] qkey,
  input  spft_pkg::wr_t              wr,
  input  logic [IDX_W-1:0]           wr_idx,
  input  spft_pkg::scan_t            scan_in,
  input  logic [IDX_W-1:0]           hit_idx_in,
  input  logic [IDX_W-1:0]           free_idx_in,
  output spft_pkg::scan_t            scan_out,
  output logic [IDX_W-1:0]           hit_idx_out,
  output logic [IDX_W-1:0]           free_idx_out
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic                        valid;
  logic [spft_pkg::KEY_W-1:0]  key;
  logic [1:0]                  kind;
  logic [spft_pkg::MASK_W-1:0] slots;
  logic                        hit;

  assign hit = valid && (key == qkey);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr_idx == MY_IDX) begin
      if (wr.set) begin
        valid <= 1'b1;
      end else if (wr.clr) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.set && wr_idx == MY_IDX) begin
      key   <= wr.key;
      kind  <= wr.kind;
      slots <= wr.slots;
    end
  end

  // merge this entry into the passing packet; earlier cells win
  always_ff @(posedge clk) begin
    scan_out.found      <= scan_in.found | hit;
    scan_out.free_found <= scan_in.free_found | !valid;
    if (scan_in.found || !hit) begin
      scan_out.kind  <= scan_in.kind;
      scan_out.slots <= scan_in.slots;
      hit_idx_out    <= hit_idx_in;
    end else begin
      scan_out.kind  <= kind;
      scan_out.slots <= slots;
      hit_idx_out    <= MY_IDX;
    end
    free_idx_out <= (scan_in.free_found || valid) ? free_idx_in : MY_IDX;
  end

endmodule

// ===== sv/spine_forwarding_table_unit.sv =====
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  request: tuser req_type, tdata address and hop masks
// m_*       out  m_tvalid/m_tready  result: tdata port_mask/status, tuser from_table
// cfg_*     in   cfg_we             register index and write data, no read-back
//
// The result is registered when the exec state commits: the key walks the chain
// of table cells one cell per cycle, then the exec state decides and writes.
// A new request is accepted only in the idle state, not during the scan or exec.
// Reset (rst, synchronous) clears all entry valid bits and the link mask, and resets config.
// A result waits in the output register; a new request is taken meanwhile, and
// its decision cycle holds until the previous result is taken.
module spine_forwarding_table_unit #(
  parameter int MAX_UP      = 16,
  parameter int MAX_DOWN    = 16,
  parameter int TABLE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [1:0] addr_type, [9:2] addr_a, [17:10] addr_b, [18] link_up,
  // [34:19] up_next_mask, [50:35] down_next_mask, [55:51] zero
  input  logic [55:0] s_tdata,
  // [1:0] req_type
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [31:0] port_mask, [34:32] status, [39:35] zero
  output logic [39:0] m_tdata,
  // [0] from_table
  output logic        m_tuser,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam logic [5:0] MAX_UP_V   = 6'(MAX_UP);
  localparam logic [5:0] MAX_DOWN_V = 6'(MAX_DOWN);

  // configuration
  logic [4:0] up_count, down_count;
  logic [1:0] own_type;
  logic [7:0] own_a, own_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      up_count   <= 5'd0;
      down_count <= 5'd0;
      own_type   <= 2'd2;
      own_a      <= 8'd0;
      own_b      <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        spft_pkg::CFG_UP_COUNT:   up_count   <= cfg_wdata[4:0];
        spft_pkg::CFG_DOWN_COUNT: down_count <= cfg_wdata[4:0];
        spft_pkg::CFG_OWN_TYPE:   own_type   <= cfg_wdata[1:0];
        spft_pkg::CFG_OWN_A:      own_a      <= cfg_wdata;
        spft_pkg::CFG_OWN_B:      own_b      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // request registers
  logic [1:0]  q_req, q_t;
  logic [7:0]  q_a, q_b;
  logic        q_lk;
  logic [15:0] q_um, q_dm;

  spft_pkg::state_t state;
  logic [IDX_W-1:0] cnt;
  logic [31:0]      slot_conn;
  logic             accept, commit;

  assign s_tready = (state == spft_pkg::S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign commit   = (state == spft_pkg::S_EXEC) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (accept) begin
      q_req <= s_tuser;
      q_t   <= s_tdata[1:0];
      q_a   <= s_tdata[9:2];
      q_b   <= s_tdata[17:10];
      q_lk  <= s_tdata[18];
      q_um  <= s_tdata[34:19];
      q_dm  <= s_tdata[50:35];
    end
  end

  // cell chain
  logic [spft_pkg::KEY_W-1:0] qkey;
  spft_pkg::wr_t              wr;
  logic [IDX_W-1:0]           wr_idx;
  spft_pkg::scan_t            chain [TABLE_DEPTH+1];
  logic [IDX_W-1:0]           hidx  [TABLE_DEPTH+1];
  logic [IDX_W-1:0]           fidx  [TABLE_DEPTH+1];

  assign qkey     = {q_t, q_a, q_b};
  assign chain[0] = '0;
  assign hidx[0]  = '0;
  assign fidx[0]  = '0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    spft_cell #(.IDX_W(IDX_W), .INDEX(i)) u_cell (
      .clk         (clk),
      .rst         (rst),
      .qkey        (qkey),
      .wr          (wr),
      .wr_idx      (wr_idx),
      .scan_in     (chain[i]),
      .hit_idx_in  (hidx[i]),
      .free_idx_in (fidx[i]),
      .scan_out    (chain[i+1]),
      .hit_idx_out (hidx[i+1]),
      .free_idx_out(fidx[i+1])
    );
  end

  spft_pkg::scan_t res;
  assign res = chain[TABLE_DEPTH];

  // decision logic, evaluated in the exec cycle
  logic [5:0]  eff_u, eff_d;
  logic [63:0] conn, up_range, down_range, dlow, bit_da, bit_ua, upm, dnm, slots64, mask;
  logic [8:0]  n_da;
  logic [4:0]  up_s, down_s;
  logic        own, dflt, ok_n;
  logic [1:0]  kind;
  logic [2:0]  st;
  logic        ft;
  logic [31:0] conn_next;

  always_comb begin
    eff_u      = ({1'b0, up_count} > MAX_UP_V) ? MAX_UP_V : {1'b0, up_count};
    eff_d      = ({1'b0, down_count} > MAX_DOWN_V) ? MAX_DOWN_V : {1'b0, down_count};
    conn       = {32'd0, slot_conn};
    up_range   = (64'd1 << eff_u) - 64'd1;
    dlow       = (64'd1 << eff_d) - 64'd1;
    down_range = dlow << eff_u;
    n_da       = {3'd0, eff_u} + {1'b0, q_a};
    bit_da     = (n_da < 9'd64) ? (64'd1 << n_da[5:0]) : 64'd0;
    bit_ua     = (q_a < 8'd64) ? (64'd1 << q_a[5:0]) : 64'd0;
    upm        = {48'd0, q_um} & up_range;
    dnm        = {48'd0, q_dm} & dlow;
    up_s       = 5'($countones(upm[15:0]));
    down_s     = 5'($countones(dnm[15:0]));
    slots64    = upm | (dnm << eff_u);
    own        = (q_t == own_type) && (q_a == own_a) && (q_b == own_b);
    mask       = 64'd0;
    st         = spft_pkg::ST_OK;
    ft         = 1'b0;
    dflt       = 1'b0;
    kind       = spft_pkg::KIND_UNREACH;
    ok_n       = 1'b0;
    conn_next  = slot_conn;
    wr         = '0;
    wr_idx     = res.found ? hidx[TABLE_DEPTH] : fidx[TABLE_DEPTH];

    case (q_req)
      spft_pkg::REQ_LOOKUP: begin
        if (own) begin
          st = spft_pkg::ST_OWN;
        end else if (res.found) begin
          ft = 1'b1;
          case (res.kind)
            spft_pkg::KIND_UNREACH: st = spft_pkg::ST_UNREACHABLE;
            spft_pkg::KIND_UP:   mask = {32'd0, res.slots} & up_range & conn;
            spft_pkg::KIND_DOWN: mask = {32'd0, res.slots} & down_range & conn;
            default: mask = {32'd0, res.slots} & (up_range | down_range) & conn;
          endcase
        end else if (q_t <= 2'd1) begin
          if ({2'd0, q_a} < {4'd0, eff_d} && (conn & bit_da) != 64'd0) mask = bit_da;
          else st = spft_pkg::ST_NO_DEFAULT;
        end else if (q_t == 2'd3 && q_b == own_a) begin
          if ({2'd0, q_a} < {4'd0, eff_u} && (conn & bit_ua) != 64'd0) mask = bit_ua;
          else st = spft_pkg::ST_NO_DEFAULT;
        end else begin
          mask = down_range & conn;
        end
      end
      spft_pkg::REQ_NEIGHBOR: begin
        if (q_t == 2'd1 && q_b == own_a && {2'd0, q_a} < {4'd0, eff_d}) begin
          ok_n = 1'b1;
          conn_next = q_lk ? (slot_conn | bit_da[31:0]) : (slot_conn & ~bit_da[31:0]);
        end else if (q_t == 2'd3 && q_b == own_a && {2'd0, q_a} < {4'd0, eff_u}) begin
          ok_n = 1'b1;
          conn_next = q_lk ? (slot_conn | bit_ua[31:0]) : (slot_conn & ~bit_ua[31:0]);
        end
        if (ok_n) mask = {32'd0, conn_next};
        else st = spft_pkg::ST_BAD_NEIGH;
      end
      spft_pkg::REQ_DEST: begin
        if (own) begin
          st = spft_pkg::ST_OWN;
        end else begin
          if (up_s != 5'd0 || down_s != 5'd0) begin
            if (q_t <= 2'd1) begin
              dflt = {2'd0, q_a} < {4'd0, eff_d} && up_s == 5'd0 && down_s == 5'd1 &&
                     (conn & bit_da) != 64'd0;
            end else if (q_t == 2'd3 && q_b == own_a) begin
              dflt = {2'd0, q_a} < {4'd0, eff_u} && (conn & bit_ua) != 64'd0;
            end else begin
              dflt = {1'b0, down_s} == eff_d && up_s == 5'd0;
            end
            kind = (up_s != 5'd0) ? ((down_s != 5'd0) ? spft_pkg::KIND_BOTH
                                                      : spft_pkg::KIND_UP)
                                  : spft_pkg::KIND_DOWN;
          end
          if (dflt) begin
            wr.clr = res.found;
          end else if (!res.found && !res.free_found) begin
            st = spft_pkg::ST_FULL;
          end else begin
            wr.set = 1'b1;
            mask   = (up_s != 5'd0 || down_s != 5'd0) ? slots64 : 64'd0;
          end
          wr.key   = qkey;
          wr.kind  = kind;
          wr.slots = mask[31:0];
        end
      end
      default: ;
    endcase

    wr.set = wr.set && commit;
    wr.clr = wr.clr && commit;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spft_pkg::S_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        spft_pkg::S_IDLE: begin
          cnt <= '0;
          if (accept) state <= spft_pkg::S_SCAN;
        end
        spft_pkg::S_SCAN: begin
          cnt <= cnt + 1'b1;
          if (cnt == IDX_W'(TABLE_DEPTH - 1)) state <= spft_pkg::S_EXEC;
        end
        spft_pkg::S_EXEC: begin
          if (commit) state <= spft_pkg::S_IDLE;
        end
        default: state <= spft_pkg::S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_conn <= 32'd0;
    end else if (commit) begin
      slot_conn <= conn_next;
    end
  end

  // output register
  logic [31:0] o_mask;
  logic [2:0]  o_st;
  logic        o_ft;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      o_mask <= mask[31:0];
      o_st   <= st;
      o_ft   <= ft;
    end
  end

  assign m_tdata = {5'd0, o_st, o_mask};
  assign m_tuser = o_ft;

  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == spft_pkg::S_SCAN)
    else $error("accepted request did not start the scan");

  a_write_exec: assert property (@(posedge clk) disable iff (rst)
    (wr.set || wr.clr) |-> (state == spft_pkg::S_EXEC && q_req == spft_pkg::REQ_DEST))
    else $error("table write outside a destination update");

  a_set_clr: assert property (@(posedge clk) disable iff (rst)
    !(wr.set && wr.clr))
    else $error("entry set and cleared together");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> ($stable(o_mask) && $stable(o_st)))
    else $error("pending result overwritten");

endmodule

// ===== bench/fwd_checker.sv =====
module fwd_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [55:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  input  logic        m_tuser,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_wdata,
  output int          fail_count,
  output int          pending
);
  localparam int DEPTH = 64;
  localparam int UP_MAX = 16;
  localparam int DOWN_MAX = 16;

  typedef struct packed {
    logic [31:0] port_mask;
    logic        from_table;
    logic [2:0]  status;
  } decision_t;

  logic [4:0]  up_cnt, down_cnt;
  logic [1:0]  own_t;
  logic [7:0]  own_a, own_b;
  logic [31:0] connected;
  logic        ent_valid [DEPTH];
  logic [17:0] ent_key [DEPTH];
  logic [1:0]  ent_kind [DEPTH];
  logic [31:0] ent_slots [DEPTH];
  decision_t   expected_q[$];

  assign pending = expected_q.size();

  function automatic logic [63:0] bit_at(int n);
    return (n < 64) ? (64'd1 << n) : 64'd0;
  endfunction

  function automatic logic [63:0] ones(int n);
    return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
  endfunction

  function automatic int hit_index(logic [17:0] key);
    for (int i = 0; i < DEPTH; i++)
      if (ent_valid[i] && ent_key[i] == key) return i;
    return -1;
  endfunction

  // forwarding decision for one request; updates the shadow table
  function automatic decision_t forward(logic [1:0] req, logic [55:0] d);
    logic [1:0]  t;
    logic [7:0]  a, b;
    logic [63:0] upm, dnm, conn, up_rng, dn_rng, slots, r, bm;
    int          nu, nd, idx, slot, ups, dns;
    logic        own, ok, covered;
    logic [1:0]  kind;
    decision_t   res;
    t = d[1:0]; a = d[9:2]; b = d[17:10];
    nu = (up_cnt > UP_MAX) ? UP_MAX : up_cnt;
    nd = (down_cnt > DOWN_MAX) ? DOWN_MAX : down_cnt;
    conn = {32'd0, connected};
    up_rng = ones(nu);
    dn_rng = ones(nd) << nu;
    res = '0;
    own = (t == own_t) && (a == own_a) && (b == own_b);
    case (spft_pkg::req_t'(req))
      spft_pkg::REQ_LOOKUP: begin
        idx = own ? -1 : hit_index({t, a, b});
        if (own) res.status = spft_pkg::ST_OWN;
        else if (idx >= 0) begin
          res.from_table = 1'b1;
          if (ent_kind[idx] == spft_pkg::KIND_UNREACH) res.status = spft_pkg::ST_UNREACHABLE;
          else begin
            r = (ent_kind[idx] == spft_pkg::KIND_UP) ? up_rng :
                (ent_kind[idx] == spft_pkg::KIND_DOWN) ? dn_rng : (up_rng | dn_rng);
            res.port_mask = 32'({32'd0, ent_slots[idx]} & r & conn);
          end
        end else if (t <= 1) begin
          if (a < nd && (conn & bit_at(nu + a)) != 0) res.port_mask = 32'(bit_at(nu + a));
          else res.status = spft_pkg::ST_NO_DEFAULT;
        end else if (t == 3 && b == own_a) begin
          if (a < nu && (conn & bit_at(a)) != 0) res.port_mask = 32'(bit_at(a));
          else res.status = spft_pkg::ST_NO_DEFAULT;
        end else res.port_mask = 32'(dn_rng & conn);
      end
      spft_pkg::REQ_NEIGHBOR: begin
        ok = 1'b0; slot = 0;
        if (t == 1 && b == own_a && a < nd) begin ok = 1'b1; slot = nu + a; end
        else if (t == 3 && b == own_a && a < nu) begin ok = 1'b1; slot = a; end
        if (!ok) res.status = spft_pkg::ST_BAD_NEIGH;
        else begin
          bm = bit_at(slot);
          if (d[18]) connected = connected | bm[31:0];
          else connected = connected & ~bm[31:0];
          res.port_mask = connected;
        end
      end
      spft_pkg::REQ_DEST: begin
        if (own) res.status = spft_pkg::ST_OWN;
        else begin
          upm = {48'd0, d[34:19]} & up_rng;
          dnm = {48'd0, d[50:35]} & ones(nd);
          ups = $countones(upm); dns = $countones(dnm);
          covered = 1'b0; kind = spft_pkg::KIND_UNREACH; slots = '0;
          if (ups != 0 || dns != 0) begin
            if (t <= 1)
              covered = a < nd && ups == 0 && dns == 1 && (conn & bit_at(nu + a)) != 0;
            else if (t == 3 && b == own_a)
              covered = a < nu && (conn & bit_at(a)) != 0;
            else covered = dns == nd && ups == 0;
            kind = (ups > 0) ? ((dns > 0) ? spft_pkg::KIND_BOTH : spft_pkg::KIND_UP)
                             : spft_pkg::KIND_DOWN;
            slots = upm | (dnm << nu);
          end
          idx = hit_index({t, a, b});
          if (covered) begin
            if (idx >= 0) ent_valid[idx] = 1'b0;
          end else begin
            if (idx < 0)
              for (int i = DEPTH - 1; i >= 0; i--) if (!ent_valid[i]) idx = i;
            if (idx < 0) res.status = spft_pkg::ST_FULL;
            else begin
              ent_valid[idx] = 1'b1;
              ent_key[idx] = {t, a, b};
              ent_kind[idx] = kind;
              ent_slots[idx] = slots[31:0];
              res.port_mask = slots[31:0];
            end
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    decision_t want;
    if (rst) begin
      up_cnt <= '0; down_cnt <= '0; own_t <= 2'd2; own_a <= '0; own_b <= '0;
      connected = '0;
      for (int i = 0; i < DEPTH; i++) ent_valid[i] = 1'b0;
      expected_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we)
        case (cfg_index)
          spft_pkg::CFG_UP_COUNT:   up_cnt <= cfg_wdata[4:0];
          spft_pkg::CFG_DOWN_COUNT: down_cnt <= cfg_wdata[4:0];
          spft_pkg::CFG_OWN_TYPE:   own_t <= cfg_wdata[1:0];
          spft_pkg::CFG_OWN_A:      own_a <= cfg_wdata;
          spft_pkg::CFG_OWN_B:      own_b <= cfg_wdata;
          default: ;
        endcase
      // result side first so a same-edge request never matches itself
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result transaction %h", m_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (m_tdata[31:0] !== want.port_mask ||
              m_tdata[34:32] !== want.status || m_tuser !== want.from_table) begin
            if (m_tdata[31:0] !== want.port_mask)
              $error("port_mask exp %h got %h", want.port_mask, m_tdata[31:0]);
            if (m_tdata[34:32] !== want.status)
              $error("status exp %0d got %0d", want.status, m_tdata[34:32]);
            if (m_tuser !== want.from_table)
              $error("from_table exp %0d got %0d", want.from_table, m_tuser);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (s_tvalid && s_tready) expected_q = {expected_q, forward(s_tuser, s_tdata)};
    end
  end
endmodule

// ===== bench/testbench.sv =====
module testbench;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;   // addr_type, addr_a, addr_b, link_up, up mask, down mask
  logic [1:0]  s_tuser = '0;   // req_type
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // port_mask, status
  logic        m_tuser;        // from_table
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [7:0]  cfg_wdata = '0;
  int          fail_count, pending;
  int          idle_cycles = 0;
  logic [7:0]  cur_own_a = 8'd0;  // mirror of own_a so neighbor updates can target it

  // each transaction walks the 64-cell chain, plus stalls
  localparam int SETTLE = 80;
  localparam int WATCHDOG = 4000;

  always #10 clk = ~clk;

  spine_forwarding_table_unit DUT (.*);

  fwd_checker u_check (.*);

  // watchdog: cycles without any accepted transaction
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("spine_forwarding_table_unit verification failed");
      $finish;
    end
  end

  // receiver backpressure: mode changes now and then, including no stalls
  int stall_mode = 0;
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      2: m_tready <= ($urandom_range(0, 1) != 0);
      default: m_tready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  int burst_left = 0;

  // hold one request until taken; gaps between bursts
  task automatic send(logic [1:0] req, logic [1:0] t, logic [7:0] a, logic [7:0] b,
                      logic lk, logic [15:0] um, logic [15:0] dm);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser <= req;
    s_tdata <= {5'd0, dm, um, lk, b, a, t};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [7:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    if (idx == spft_pkg::CFG_OWN_A) cur_own_a = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(logic [4:0] u, logic [4:0] d, logic [1:0] ot,
                           logic [7:0] oa, logic [7:0] ob);
    write_reg(spft_pkg::CFG_UP_COUNT, {3'd0, u});
    write_reg(spft_pkg::CFG_DOWN_COUNT, {3'd0, d});
    write_reg(spft_pkg::CFG_OWN_TYPE, {6'd0, ot});
    write_reg(spft_pkg::CFG_OWN_A, oa);
    write_reg(spft_pkg::CFG_OWN_B, ob);
  endtask

  // random request: mostly valid neighbor links and small address space
  task automatic random_item();
    logic [1:0] t;
    logic [7:0] a, b;
    logic [1:0] req;
    int pick;
    pick = $urandom_range(0, 99);
    t = 2'($urandom_range(0, 3));
    a = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 20));
    b = ($urandom_range(0, 1) == 0) ? cur_own_a : 8'($urandom_range(0, 7));
    if ($urandom_range(0, 9) == 0) b = 8'($urandom);
    req = (pick < 40) ? spft_pkg::REQ_LOOKUP : (pick < 65) ? spft_pkg::REQ_NEIGHBOR :
          (pick < 97) ? spft_pkg::REQ_DEST : spft_pkg::REQ_UNUSED;
    if (req == spft_pkg::REQ_NEIGHBOR && $urandom_range(0, 4) != 0) begin
      t = $urandom_range(0, 1) ? 2'd1 : 2'd3;
      b = cur_own_a;
    end
    send(req, t, a, b, $urandom_range(0, 3) != 0, 16'($urandom), 16'($urandom));
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // defaults after reset: no links, empty table
    send(spft_pkg::REQ_LOOKUP, 2'd2, 8'd0, 8'd0, 1'b0, 16'h0, 16'h0);   // own address
    send(spft_pkg::REQ_LOOKUP, 2'd0, 8'd1, 8'd0, 1'b0, 16'h0, 16'h0);   // no default port
    drain();

    configure(5'd4, 5'd4, 2'd2, 8'd5, 8'd9);
    // connect up and down slots, invalid neighbor, unused request
    send(spft_pkg::REQ_NEIGHBOR, 2'd3, 8'd0, 8'd5, 1'b1, 16'h0, 16'h0);
    send(spft_pkg::REQ_NEIGHBOR, 2'd3, 8'd3, 8'd5, 1'b1, 16'h0, 16'h0);
    send(spft_pkg::REQ_NEIGHBOR, 2'd1, 8'd1, 8'd5, 1'b1, 16'h0, 16'h0);
    send(spft_pkg::REQ_NEIGHBOR, 2'd1, 8'd4, 8'd5, 1'b1, 16'h0, 16'h0);  // bad neighbor
    send(spft_pkg::REQ_NEIGHBOR, 2'd2, 8'd0, 8'd5, 1'b1, 16'h0, 16'h0);  // bad type
    send(spft_pkg::REQ_UNUSED, 2'd3, 8'hff, 8'hff, 1'b1, 16'hffff, 16'hffff);
    // defaults for all address types
    send(spft_pkg::REQ_LOOKUP, 2'd0, 8'd1, 8'd0, 1'b0, 16'h0, 16'h0);
    send(spft_pkg::REQ_LOOKUP, 2'd1, 8'd2, 8'd0, 1'b0, 16'h0, 16'h0);
    send(spft_pkg::REQ_LOOKUP, 2'd2, 8'd7, 8'd7, 1'b0, 16'h0, 16'h0);
    send(spft_pkg::REQ_LOOKUP, 2'd3, 8'd3, 8'd5, 1'b0, 16'h0, 16'h0);
    send(spft_pkg::REQ_LOOKUP, 2'd3, 8'd3, 8'd6, 1'b0, 16'h0, 16'h0);
    // destination updates: unreachable, up, both, covered, own
    send(spft_pkg::REQ_DEST, 2'd0, 8'd9, 8'd1, 1'b0, 16'h0, 16'h0);
    send(spft_pkg::REQ_LOOKUP, 2'd0, 8'd9, 8'd1, 1'b0, 16'h0, 16'h0);
    send(spft_pkg::REQ_DEST, 2'd2, 8'd1, 8'd1, 1'b0, 16'hffff, 16'h0);
    send(spft_pkg::REQ_DEST, 2'd3, 8'hff, 8'hff, 1'b1, 16'hffff, 16'hffff);
    send(spft_pkg::REQ_LOOKUP, 2'd3, 8'hff, 8'hff, 1'b0, 16'h0, 16'h0);
    send(spft_pkg::REQ_DEST, 2'd0, 8'd1, 8'd0, 1'b0, 16'h0, 16'h0002);   // default covers
    send(spft_pkg::REQ_DEST, 2'd2, 8'd5, 8'd9, 1'b0, 16'h1, 16'h0);      // own address
    send(spft_pkg::REQ_NEIGHBOR, 2'd3, 8'd0, 8'd5, 1'b0, 16'h0, 16'h0);  // disconnect
    drain();

    // fill the table to overflow with distinct keys
    configure(5'd16, 5'd16, 2'd1, 8'd0, 8'd0);
    for (int i = 0; i < 66; i++)
      send(spft_pkg::REQ_DEST, 2'd2, 8'(i), 8'd200, 1'b0, 16'h8001, 16'h0);
    send(spft_pkg::REQ_LOOKUP, 2'd2, 8'd3, 8'd200, 1'b0, 16'h0, 16'h0);
    drain();

    // random phases over several settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: configure(5'd0, 5'd0, 2'd0, 8'd0, 8'd0);
        1: configure(5'd31, 5'd31, 2'd3, 8'd255, 8'd255);
        2: configure(5'd16, 5'd16, 2'd3, 8'd2, 8'd1);
        default: configure(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                           2'($urandom_range(0, 3)), 8'($urandom_range(0, 7)),
                           8'($urandom));
      endcase
      // erase some entries by covering them so the table does not stay full
      for (int i = 0; i < 210; i++) random_item();
      drain();
    end

    if (fail_count == 0) begin
      $display("spine_forwarding_table_unit verification clean");
    end else begin
      $display("spine_forwarding_table_unit verification failed");
    end
    $finish;
  end
endmodule
